// ===== rtl/eida_pkg.sv =====
// shared types and constants of the entity id allocator
package eida_pkg;

	localparam int POOL_SIZE_DEF = 256;

	localparam int REQ_TYPE_W = 2;
	localparam int ENTITY_W   = 8;
	localparam int COUNT_W    = 9;
	localparam int STATUS_W   = 2;

	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC_ONE   = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC_BATCH = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE     = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INACTIVE     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [ENTITY_W-1:0]   entity;
		logic [COUNT_W-1:0]    count;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ENTITY_W-1:0] entity_id;
		logic [COUNT_W-1:0]  active_count;
	} rsp_t;

endpackage

// ===== rtl/eida_stream_if.sv =====
// valid/ready channel carrying one payload item per transfer
interface eida_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/entity_id_allocator.sv =====
// entity id allocator top level: free stack, fresh id mark and active bits
//
//   channel  dir  payload                              transfer
//   req      in   req_type, entity, count              req.valid && req.ready
//   rsp      out  status, entity_id, active_count      rsp.valid && rsp.ready
//
// allocate one, release and unused types go through transfer, then execute
// batch of zero or too large likewise; else execute, S_BPOP per fresh id, S_BPOP then
// S_BWR per popped id, then S_DONE; after reset the active-bit ram clears, req.ready low
// execute waits while the result register holds an untaken result
// req.ready is high only in idle; a result may wait while the next req transfers
module entity_id_allocator #(
	parameter int POOL_SIZE = eida_pkg::POOL_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	eida_stream_if.sink        req,
	eida_stream_if.source      rsp
);
	import eida_pkg::*;

	localparam int IDW  = $clog2(POOL_SIZE);
	localparam int CW   = $clog2(POOL_SIZE + 1);
	localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [CW-1:0]   POOL_CW = CW'(POOL_SIZE);
	localparam logic [CW-1:0]   LAST_CW = CW'(POOL_SIZE - 1);
	localparam logic [CMPW-1:0] POOL_C  = CMPW'(POOL_SIZE);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_BPOP  = 6'b001000,
		S_BWR   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] clr_q, clr_d;
	logic [CW-1:0] hw_q, hw_d;
	logic [CW-1:0] depth_q, depth_d;
	logic [CW-1:0] live_q, live_d;
	logic [COUNT_W-1:0] rem_q, rem_d;
	req_t req_q;
	logic [CW-1:0] room;

	logic            act_we, act_wdata, act_re, act_rdata;
	logic [IDW-1:0]  act_waddr, act_raddr;
	logic            stk_we, stk_re;
	logic [IDW-1:0]  stk_waddr, stk_wdata, stk_raddr, stk_rdata;

	logic                rsp_valid_q;
	rsp_t                rsp_q;
	logic                go, load;
	logic [STATUS_W-1:0] ld_status;
	logic [ENTITY_W-1:0] ld_id;

	eida_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_active_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (act_wdata),
		.re    (act_re),
		.raddr (act_raddr),
		.rdata (act_rdata)
	);

	eida_ram #(.WIDTH(IDW), .DEPTH(POOL_SIZE)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign go        = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign room      = POOL_CW - hw_q + depth_q;

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		hw_d      = hw_q;
		depth_d   = depth_q;
		live_d    = live_q;
		rem_d     = rem_q;
		act_we    = 1'b0;
		act_waddr = IDW'(hw_q);
		act_wdata = 1'b1;
		act_re    = 1'b0;
		act_raddr = IDW'(req.data.entity);
		stk_we    = 1'b0;
		stk_waddr = IDW'(depth_q);
		stk_wdata = IDW'(req_q.entity);
		stk_re    = 1'b0;
		stk_raddr = IDW'(depth_q - 1'b1);
		load      = 1'b0;
		ld_status = ST_OK;
		ld_id     = '0;
		case (state_q)
			S_CLEAR: begin
				act_we    = 1'b1;
				act_waddr = IDW'(clr_q);
				act_wdata = 1'b0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == LAST_CW) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					act_re  = 1'b1;
					stk_re  = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (req_q.req_type)
					REQ_ALLOC_ONE: begin
						if (go) begin
							load    = 1'b1;
							state_d = S_IDLE;
							if (hw_q < POOL_CW) begin
								act_we = 1'b1;
								hw_d   = hw_q + 1'b1;
								live_d = live_q + 1'b1;
								ld_id  = ENTITY_W'(hw_q);
							end else if (depth_q != '0) begin
								act_we    = 1'b1;
								act_waddr = stk_rdata;
								depth_d   = depth_q - 1'b1;
								live_d    = live_q + 1'b1;
								ld_id     = ENTITY_W'(stk_rdata);
							end else begin
								ld_status = ST_POOL_FULL;
							end
						end
					end
					REQ_ALLOC_BATCH: begin
						if (CMPW'(req_q.count) > CMPW'(room)) begin
							if (go) begin
								load      = 1'b1;
								ld_status = ST_POOL_FULL;
								state_d   = S_IDLE;
							end
						end else if (req_q.count == '0) begin
							if (go) begin
								load    = 1'b1;
								state_d = S_IDLE;
							end
						end else begin
							rem_d   = req_q.count;
							state_d = S_BPOP;
						end
					end
					REQ_RELEASE: begin
						if (go) begin
							load    = 1'b1;
							state_d = S_IDLE;
							ld_id   = req_q.entity;
							if (CMPW'(req_q.entity) >= POOL_C) begin
								ld_status = ST_OUT_OF_RANGE;
							end else if (!act_rdata) begin
								ld_status = ST_INACTIVE;
							end else begin
								act_we    = 1'b1;
								act_waddr = IDW'(req_q.entity);
								act_wdata = 1'b0;
								if (depth_q < POOL_CW) begin
									stk_we  = 1'b1;
									depth_d = depth_q + 1'b1;
								end
								if (live_q != '0) begin
									live_d = live_q - 1'b1;
								end
							end
						end
					end
					default: begin
						if (go) begin
							load    = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_BPOP: begin
				if (depth_q != '0) begin
					stk_re  = 1'b1;
					state_d = S_BWR;
				end else begin
					act_we = 1'b1;
					hw_d   = hw_q + 1'b1;
					live_d = live_q + 1'b1;
					rem_d  = rem_q - 1'b1;
					if (rem_q == COUNT_W'(1)) begin
						state_d = S_DONE;
					end
				end
			end
			S_BWR: begin
				act_we    = 1'b1;
				act_waddr = stk_rdata;
				depth_d   = depth_q - 1'b1;
				live_d    = live_q + 1'b1;
				rem_d     = rem_q - 1'b1;
				state_d   = (rem_q == COUNT_W'(1)) ? S_DONE : S_BPOP;
			end
			S_DONE: begin
				if (go) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hw_q        <= '0;
			depth_q     <= '0;
			live_q      <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			hw_q    <= hw_d;
			depth_q <= depth_d;
			live_q  <= live_d;
			rem_q   <= rem_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.data;
		end
		if (load) begin
			rsp_q.status       <= ld_status;
			rsp_q.entity_id    <= ld_id;
			rsp_q.active_count <= COUNT_W'(live_d);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef SYNTHESIS
	a_id_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(depth_q) + (CW + 1)'(live_q) == (CW + 1)'(hw_q))
		else $error("free depth plus live count differs from high-water mark");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !req.ready)
		else $error("request taken during active-bit clearing");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_EXEC))
		else $error("accepted request did not enter execute");

	a_batch_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BPOP || state_q == S_BWR) |-> (rem_q != '0))
		else $error("batch step with nothing left to allocate");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= POOL_CW)
		else $error("live count above pool size");
`endif
endmodule

// ===== rtl/eida_ram.sv =====
// generic single write port, single read port ram with registered read
module eida_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== dv/id_pool_checker.sv =====
// checker for the entity id allocator: models the id pool and compares every result
module id_pool_checker #(
	parameter int POOL = eida_pkg::POOL_SIZE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  eida_pkg::req_t  req_data,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  eida_pkg::rsp_t  rsp_data,
	output int              errors,
	output int              pending,
	output int              results,
	output int              full_hits,
	output int              inactive_hits,
	output int              peak_live
);
	import eida_pkg::*;

	bit                  in_use [POOL];
	logic [ENTITY_W-1:0] freed [POOL];
	int unsigned         freed_n;
	int unsigned         fresh_mark;
	int unsigned         live;
	rsp_t                expected_rsp [$];
	rsp_t                want;

	task automatic report(input string msg);
		$display("[%0t] %s", $time, msg);
		errors++;
	endtask

	function automatic rsp_t pool_step(input req_t r);
		rsp_t        o;
		int unsigned room;
		int unsigned id;
		o.status    = ST_OK;
		o.entity_id = '0;
		id          = 0;
		case (r.req_type)
			REQ_ALLOC_ONE: begin
				if (fresh_mark < POOL) begin
					id = fresh_mark;
					fresh_mark++;
				end else if (freed_n > 0) begin
					freed_n--;
					id = freed[freed_n];
				end else begin
					o.status = ST_POOL_FULL;
				end
				if (o.status == ST_OK) begin
					in_use[id]  = 1'b1;
					live++;
					o.entity_id = id[ENTITY_W-1:0];
				end
			end
			REQ_ALLOC_BATCH: begin
				room = (POOL - fresh_mark) + freed_n;
				if (r.count > room) begin
					o.status = ST_POOL_FULL;
				end else begin
					// freed ids go first, then fresh ones
					for (int k = 0; k < r.count; k++) begin
						if (freed_n > 0) begin
							freed_n--;
							id = freed[freed_n];
						end else begin
							id = fresh_mark;
							fresh_mark++;
						end
						in_use[id] = 1'b1;
						live++;
					end
				end
			end
			REQ_RELEASE: begin
				o.entity_id = r.entity;
				if (r.entity >= POOL) begin
					o.status = ST_OUT_OF_RANGE;
				end else if (!in_use[r.entity]) begin
					o.status = ST_INACTIVE;
				end else begin
					in_use[r.entity] = 1'b0;
					if (freed_n < POOL) begin
						freed[freed_n] = r.entity;
						freed_n++;
					end
					if (live > 0)
						live--;
				end
			end
			default: ;
		endcase
		o.active_count = live[COUNT_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use        = '{default: 1'b0};
			freed_n       = 0;
			expected_rsp.delete();
			fresh_mark    = 0;
			live          = 0;
			errors        = 0;
			pending       = 0;
			results       = 0;
			full_hits     = 0;
			inactive_hits = 0;
			peak_live     = 0;
		end else begin
			if (req_valid && req_ready) begin
				want = pool_step(req_data);
				expected_rsp.insert(expected_rsp.size(), want);
				if (want.status == ST_POOL_FULL)
					full_hits++;
				if (want.status == ST_INACTIVE)
					inactive_hits++;
				if (int'(live) > peak_live)
					peak_live = int'(live);
			end
			if (rsp_valid && rsp_ready) begin
				results++;
				if (expected_rsp.size() == 0) begin
					report($sformatf("result with nothing expected: status %0d id %0d count %0d",
						rsp_data.status, rsp_data.entity_id, rsp_data.active_count));
				end else begin
					want = expected_rsp.pop_front();
					if (rsp_data.status !== want.status)
						report($sformatf("status mismatch: got %0d expected %0d",
							rsp_data.status, want.status));
					if (rsp_data.entity_id !== want.entity_id)
						report($sformatf("entity_id mismatch: got %0d expected %0d",
							rsp_data.entity_id, want.entity_id));
					if (rsp_data.active_count !== want.active_count)
						report($sformatf("active_count mismatch: got %0d expected %0d",
							rsp_data.active_count, want.active_count));
				end
			end
			pending = expected_rsp.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the entity id allocator: clock, reset, request stimulus and verdict
module tb_top;
	import eida_pkg::*;

	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   sent;
	int   quiet;
	int   errors, pending, results, full_hits, inactive_hits, peak_live;

	eida_stream_if #(.T(req_t)) req_ch ();
	eida_stream_if #(.T(rsp_t)) rsp_ch ();

	entity_id_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	id_pool_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_ch.valid),
		.req_ready     (req_ch.ready),
		.req_data      (req_ch.data),
		.rsp_valid     (rsp_ch.valid),
		.rsp_ready     (rsp_ch.ready),
		.rsp_data      (rsp_ch.data),
		.errors        (errors),
		.pending       (pending),
		.results       (results),
		.full_hits     (full_hits),
		.inactive_hits (inactive_hits),
		.peak_live     (peak_live)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int stall_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic req_t mk(input logic [REQ_TYPE_W-1:0] t, input logic [ENTITY_W-1:0] e,
		input logic [COUNT_W-1:0] c);
		req_t r;
		r.req_type = t;
		r.entity   = e;
		r.count    = c;
		return r;
	endfunction

	function automatic req_t rand_req(input mix_t mix);
		int   p;
		int   q;
		req_t r;
		p = $urandom_range(0, 99);
		q = $urandom_range(0, 19);
		r.entity = ENTITY_W'($urandom_range(0, 255));
		if (q < 15)
			r.count = COUNT_W'($urandom_range(0, 8));
		else if (q < 18)
			r.count = COUNT_W'($urandom_range(0, 256));
		else
			r.count = COUNT_W'($urandom_range(0, 511));
		case (mix)
			MIX_FILL:  r.req_type = (p < 55) ? REQ_ALLOC_ONE : (p < 80) ? REQ_ALLOC_BATCH :
				(p < 99) ? REQ_RELEASE : REQ_UNUSED;
			MIX_DRAIN: r.req_type = (p < 15) ? REQ_ALLOC_ONE : (p < 20) ? REQ_ALLOC_BATCH :
				(p < 99) ? REQ_RELEASE : REQ_UNUSED;
			default:   r.req_type = (p < 33) ? REQ_ALLOC_ONE : (p < 50) ? REQ_ALLOC_BATCH :
				(p < 98) ? REQ_RELEASE : REQ_UNUSED;
		endcase
		return r;
	endfunction

	task automatic issue(input req_t r);
		int gap;
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : stall_len();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	// result-side backpressure
	initial begin
		int hold;
		rsp_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				rsp_ch.ready <= 1'b1;
				hold = $urandom_range(0, 8);
			end else begin
				rsp_ch.ready <= 1'b0;
				hold = stall_len() - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results outstanding", quiet, pending);
				$display("entity_id_allocator test failed");
				$finish;
			end
		end
	end

	initial begin
		mix_t mix;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		arst_n       = 1'b0;
		calm         = 1'b0;
		sent         = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pool, zero and oversized batches, exhaustion, lifo reuse
		issue(mk(REQ_RELEASE, 8'd0, 9'd0));
		issue(mk(REQ_ALLOC_ONE, 8'd0, 9'd0));
		issue(mk(REQ_ALLOC_BATCH, 8'd0, 9'd0));
		issue(mk(REQ_ALLOC_BATCH, 8'd0, 9'd511));
		issue(mk(REQ_ALLOC_BATCH, 8'd0, 9'd256));
		issue(mk(REQ_RELEASE, 8'd0, 9'd0));
		issue(mk(REQ_RELEASE, 8'd0, 9'd0));
		issue(mk(REQ_UNUSED, 8'd255, 9'd511));
		issue(mk(REQ_ALLOC_BATCH, 8'd0, 9'd255));
		issue(mk(REQ_ALLOC_ONE, 8'd0, 9'd0));
		issue(mk(REQ_ALLOC_ONE, 8'd0, 9'd0));
		issue(mk(REQ_ALLOC_BATCH, 8'd0, 9'd1));
		issue(mk(REQ_RELEASE, 8'd255, 9'd0));
		issue(mk(REQ_RELEASE, 8'd170, 9'd0));
		issue(mk(REQ_RELEASE, 8'd85, 9'd0));
		issue(mk(REQ_ALLOC_ONE, 8'd0, 9'd0));
		issue(mk(REQ_ALLOC_BATCH, 8'd0, 9'd3));
		issue(mk(REQ_ALLOC_BATCH, 8'd0, 9'd2));
		issue(mk(REQ_RELEASE, 8'd255, 9'd0));
		issue(mk(REQ_ALLOC_ONE, 8'd0, 9'd0));

		for (int blk = 0; blk < 30; blk++) begin
			mix  = mix_t'($urandom_range(0, 2));
			calm = ($urandom_range(0, 3) == 0);
			repeat (40) issue(rand_req(mix));
		end
		calm = 1'b0;

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d requests and checked %0d results", sent, results);
		$display("pool-full statuses %0d, inactive releases %0d, peak active count %0d",
			full_hits, inactive_hits, peak_live);
		if (errors == 0 && pending == 0)
			$display("entity_id_allocator test passed");
		else
			$display("entity_id_allocator test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/eida_pkg.sv
rtl/eida_stream_if.sv
rtl/eida_ram.sv
rtl/entity_id_allocator.sv
dv/id_pool_checker.sv
dv/tb_top.sv
